// ===== hdl/lirs_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
`timescale 1ns / 1ps
`default_nettype none
package lirs_pkg;

  // Transaction opcodes on the input channel
  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } lirs_op_t;

  // Result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration register indexes
  typedef enum logic {
    REG_PITCH = 1'b0,
    REG_FRAME = 1'b1
  } lirs_reg_t;

  localparam logic [15:0] PITCH_RESET = 16'd32768;
  localparam logic [15:0] PITCH_MIN   = 16'd512;
  localparam logic [11:0] FRAME_RESET = 12'd184;

  // Classified command passed from the front end to the engine
  typedef struct packed {
    lirs_op_t           op;
    logic signed [15:0] sample;  // input sample, or restored sample on start
    logic        [15:0] phase;   // restored phase as a 16-bit fraction on start
  } lirs_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/lirs_front.sv =====
// Input stage: accept transactions and classify them into engine commands.
`timescale 1ns / 1ps
`default_nettype none
module lirs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                op,
  input  logic signed [15:0]  sample_in,
  input  logic                clear_history,
  input  logic signed [15:0]  saved_sample,
  input  logic        [15:0]  saved_phase,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output lirs_pkg::lirs_cmd_t cmd
);
  import lirs_pkg::*;

  lirs_cmd_t cmd_next;

  assign item_ready = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next.op = lirs_op_t'(op);
    if (lirs_op_t'(op) == OP_START) begin
      // clear zeroes both the history sample and the phase
      cmd_next.sample = clear_history ? 16'sd0 : saved_sample;
      cmd_next.phase  = clear_history ? 16'd0 : saved_phase;
    end else begin
      cmd_next.sample = sample_in;
      cmd_next.phase  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lirs_queue.sv =====
// Two-entry command queue between the front end and the engine.
`timescale 1ns / 1ps
`default_nettype none
module lirs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  lirs_pkg::lirs_cmd_t wr_cmd,
  output logic                rd_valid,
  input  logic                rd_ready,
  output lirs_pkg::lirs_cmd_t rd_cmd
);
  import lirs_pkg::*;

  lirs_cmd_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

endmodule
`default_nettype wire

// ===== hdl/lirs_back.sv =====
// Interpolation engine: frame state, phase accumulator and result register.
`timescale 1ns / 1ps
`default_nettype none
module lirs_back #(
  parameter int PHASE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic        [15:0]  pitch_raw,
  input  logic        [11:0]  frame_outputs,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  lirs_pkg::lirs_cmd_t cmd,
  output logic                result_valid,
  input  logic                result_ready,
  output logic                kind,
  output logic signed [15:0]  sample_out,
  output logic                last_of_run,
  output logic                frame_end,
  output logic signed [15:0]  save_sample,
  output logic        [15:0]  save_phase
);
  import lirs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } lirs_state_t;

  lirs_state_t               state;
  logic signed [15:0]        prev_sample;
  logic signed [15:0]        cur_sample;
  logic [PHASE_BITS-1:0]     phase;
  logic                      skip_pending;
  logic [11:0]               outputs_left;
  logic                      frame_active;

  logic                      slot_free;
  logic [15:0]               pitch_eff;
  logic [PHASE_BITS+16:0]    pitch_ext;
  logic [PHASE_BITS:0]       inc;
  logic [PHASE_BITS+1:0]     acc;
  logic [1:0]                carry;
  logic [PHASE_BITS-1:0]     phase_next;
  logic [11:0]               left_next;
  logic signed [15:0]        prev_next;
  logic signed [16:0]        diff;
  logic signed [PHASE_BITS+17:0] prod;
  logic signed [PHASE_BITS+17:0] prod_shr;
  logic [15:0]               interp;
  logic [PHASE_BITS-1:0]     start_phase;

  // 16-bit field fraction to PHASE_BITS fraction and back
  function automatic logic [PHASE_BITS-1:0] align_in(input logic [15:0] v);
    logic [PHASE_BITS+15:0] ext;
    ext = {v, {PHASE_BITS{1'b0}}};
    return ext[PHASE_BITS+15:16];
  endfunction

  function automatic logic [15:0] align_out(input logic [PHASE_BITS-1:0] p);
    logic [PHASE_BITS+15:0] ext;
    ext = {p, 16'h0000};
    return ext[PHASE_BITS+15:PHASE_BITS];
  endfunction

  assign slot_free = !result_valid || result_ready;
  assign cmd_ready = (state == ST_IDLE) && slot_free;

  // phase increment: twice the clamped pitch, aligned to the accumulator
  assign pitch_eff = (pitch_raw < PITCH_MIN) ? PITCH_MIN : pitch_raw;
  assign pitch_ext = {pitch_eff, 1'b0, {PHASE_BITS{1'b0}}};
  assign inc       = pitch_ext[PHASE_BITS+16:16];

  assign acc        = {2'b00, phase} + {1'b0, inc};
  assign carry      = acc[PHASE_BITS+1:PHASE_BITS];
  assign phase_next = acc[PHASE_BITS-1:0];
  assign left_next  = outputs_left - 12'd1;
  assign prev_next  = (carry != 2'd0) ? cur_sample : prev_sample;

  // floor((cur - prev) * phase / 2^PHASE_BITS); arithmetic shift rounds down
  assign diff     = {cur_sample[15], cur_sample} - {prev_sample[15], prev_sample};
  assign prod     = diff * $signed({1'b0, phase});
  assign prod_shr = prod >>> PHASE_BITS;
  assign interp   = prev_sample + prod_shr[15:0];

  assign start_phase = align_in(cmd.phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prev_sample  <= 16'sd0;
      phase        <= '0;
      skip_pending <= 1'b0;
      outputs_left <= 12'd0;
      frame_active <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            case (cmd.op)
              OP_START: begin
                prev_sample  <= cmd.sample;
                phase        <= start_phase;
                skip_pending <= 1'b0;
                outputs_left <= frame_outputs;
                frame_active <= (frame_outputs != 12'd0);
                if (frame_outputs == 12'd0) begin
                  result_valid <= 1'b1;
                end
              end
              OP_SAMPLE: begin
                if (frame_active && skip_pending) begin
                  // absorb this sample without interpolating
                  prev_sample  <= cmd.sample;
                  skip_pending <= 1'b0;
                  if (outputs_left == 12'd0) begin
                    frame_active <= 1'b0;
                    result_valid <= 1'b1;
                  end
                end else if (frame_active) begin
                  state <= ST_RUN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            outputs_left <= left_next;
            phase        <= phase_next;
            prev_sample  <= prev_next;
            if (carry[1]) skip_pending <= 1'b1;
            if (left_next == 12'd0 && !carry[1]) frame_active <= 1'b0;
            // a carry is reached within 64 steps at the minimum pitch
            if (carry != 2'd0 || left_next == 12'd0) state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && cmd_ready) begin
      cur_sample  <= cmd.sample;
      kind        <= KIND_REPORT;
      sample_out  <= 16'sd0;
      last_of_run <= 1'b1;
      frame_end   <= 1'b1;
      save_sample <= cmd.sample;
      save_phase  <= (cmd.op == OP_START) ? align_out(start_phase) : align_out(phase);
    end else if (state == ST_RUN && slot_free) begin
      kind        <= KIND_SAMPLE;
      sample_out  <= interp;
      last_of_run <= (carry != 2'd0) || (left_next == 12'd0);
      if (left_next == 12'd0 && !carry[1]) begin
        frame_end   <= 1'b1;
        save_sample <= prev_next;
        save_phase  <= align_out(phase_next);
      end else begin
        frame_end   <= 1'b0;
        save_sample <= 16'sd0;
        save_phase  <= 16'd0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/linear_interp_resampler_core.sv =====
// Top level of the linear interpolation audio resampler.
`timescale 1ns / 1ps
`default_nettype none
// Linear interpolation sample-rate converter. Send a start transaction (op 0)
// to open a frame, restoring the saved sample and phase or clearing both, then
// input samples (op 1). Each sample yields zero to 64 interpolated results,
// prev + floor((cur - prev) * phase / 2^PHASE_BITS), one per cycle while
// results are accepted; the last result of a frame carries frame_end and the
// sample and phase to save for the next frame.
// When a frame closes on a double phase carry, the next input sample is
// absorbed and returns a report-only result (kind 1). The engine takes a
// command from the queue while idle and only then produces that sample's
// interpolated results; a start or absorbed sample needs only the take. It
// takes no new command until the last result of a run is in the single
// result register. A two-entry command queue plus the input register let the
// input side keep taking transactions while results stall. Write pitch_raw
// and frame_outputs only while idle.
module linear_interp_resampler_core #(
  parameter int PHASE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [15:0] cfg_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               op,
  input  logic signed [15:0] sample_in,
  input  logic               clear_history,
  input  logic signed [15:0] saved_sample,
  input  logic        [15:0] saved_phase,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               kind,
  output logic signed [15:0] sample_out,
  output logic               last_of_run,
  output logic               frame_end,
  output logic signed [15:0] save_sample,
  output logic        [15:0] save_phase
);
  import lirs_pkg::*;

  logic [15:0] pitch_raw;
  logic [11:0] frame_outputs;

  logic      front_valid;
  logic      front_ready;
  lirs_cmd_t front_cmd;
  logic      q_valid;
  logic      q_ready;
  lirs_cmd_t q_cmd;

  // Configuration registers: write takes effect on the enable edge
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_raw     <= PITCH_RESET;
      frame_outputs <= FRAME_RESET;
    end else if (cfg_we) begin
      case (lirs_reg_t'(cfg_index))
        REG_PITCH: pitch_raw     <= cfg_data;
        REG_FRAME: frame_outputs <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: register and classify each input transaction
  lirs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .op            (op),
    .sample_in     (sample_in),
    .clear_history (clear_history),
    .saved_sample  (saved_sample),
    .saved_phase   (saved_phase),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready),
    .cmd           (front_cmd)
  );

  // Decouple the front end from the engine
  lirs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  // Engine: frame state, interpolation and the output register
  lirs_back #(
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pitch_raw     (pitch_raw),
    .frame_outputs (frame_outputs),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .kind          (kind),
    .sample_out    (sample_out),
    .last_of_run   (last_of_run),
    .frame_end     (frame_end),
    .save_sample   (save_sample),
    .save_phase    (save_phase)
  );

endmodule
`default_nettype wire

// ===== hdl/lirs_checker.sv =====
// Port-level assertions for the resampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lirs_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_ready,
  input logic               kind,
  input logic signed [15:0] sample_out,
  input logic               last_of_run,
  input logic               frame_end,
  input logic signed [15:0] save_sample,
  input logic        [15:0] save_phase
);
  import lirs_pkg::*;

  // Hold a stalled result unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid &&
      $stable({kind, sample_out, last_of_run, frame_end, save_sample, save_phase}))
    else $error("stalled result changed");

  // A report closes a frame, ends its run and carries no sample
  a_report: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_REPORT |-> frame_end && last_of_run && sample_out == 16'sd0)
    else $error("malformed report");

  // Frame end always falls on the last result of a run
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> last_of_run)
    else $error("frame end not on last result");

  // Save fields stay zero outside a frame end
  a_save_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !frame_end |-> save_sample == 16'sd0 && save_phase == 16'd0)
    else $error("save fields set without frame end");

endmodule

bind linear_interp_resampler_core lirs_checker u_lirs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .kind         (kind),
  .sample_out   (sample_out),
  .last_of_run  (last_of_run),
  .frame_end    (frame_end),
  .save_sample  (save_sample),
  .save_phase   (save_phase)
);
`default_nettype wire

// ===== sim/linear_interp_resampler_core_tb.sv =====
// Self-checking testbench for the linear interpolation resampler core.
`timescale 1ns / 1ps
module linear_interp_resampler_core_tb;
  import lirs_pkg::*;

  // Quiet cycles after the last awaited result before touching the registers:
  // input register, two-entry command queue and the engine may still hold a
  // start or an absorbed sample that produces nothing.
  localparam int SETTLE_CYCLES = 16;
  // Watchdog: cycles without any transaction before the run is declared hung.
  localparam int HANG_LIMIT    = 1000;
  localparam int MAX_REPORTED  = 10;

  // One result transaction, in port order.
  typedef struct packed {
    logic        kind;
    logic [15:0] sample;
    logic        last;
    logic        fend;
    logic [15:0] save_smp;
    logic [15:0] save_ph;
  } resamp_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  lirs_reg_t          cfg_index = REG_PITCH;
  logic        [15:0] cfg_data = '0;
  logic               item_valid = 1'b0;
  logic               item_ready;
  lirs_op_t           op = OP_START;
  logic signed [15:0] sample_in = '0;
  logic               clear_history = 1'b0;
  logic signed [15:0] saved_sample = '0;
  logic        [15:0] saved_phase = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic               kind;
  logic signed [15:0] sample_out;
  logic               last_of_run;
  logic               frame_end;
  logic signed [15:0] save_sample;
  logic        [15:0] save_phase;

  linear_interp_resampler_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .sample_in    (sample_in),
    .clear_history(clear_history),
    .saved_sample (saved_sample),
    .saved_phase  (saved_phase),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .sample_out   (sample_out),
    .last_of_run  (last_of_run),
    .frame_end    (frame_end),
    .save_sample  (save_sample),
    .save_phase   (save_phase)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Resampler shadow state: configuration and frame context as the block
  // should hold them after every accepted transaction.
  // ---------------------------------------------------------------------------
  logic        [15:0] m_pitch = PITCH_RESET;
  logic        [11:0] m_frame = FRAME_RESET;
  logic signed [15:0] m_prev = '0;
  logic        [15:0] m_phase = '0;
  logic               m_skip = 1'b0;
  logic        [11:0] m_left = '0;
  logic               m_active = 1'b0;

  resamp_out_t resampled_q[$];   // results owed by the block, oldest first

  int n_items = 0;
  int n_results = 0;
  int n_reports = 0;
  int n_frame_ends = 0;
  int n_settings = 0;
  int mismatches = 0;

  bit tx_burst = 1'b0;   // sender idles between transactions unless set
  bit rx_burst = 1'b0;   // receiver stalls between results unless set

  // prev + floor((cur - prev) * phase / 2^16), wrapped to 16 bits. The
  // arithmetic shift of the exact signed product rounds toward minus infinity.
  function automatic logic [15:0] interp_at(logic signed [15:0] cur);
    longint diff;
    longint prod;
    longint q;
    diff = longint'(cur) - longint'(m_prev);
    prod = diff * longint'({1'b0, m_phase});
    q = prod >>> 16;
    return 16'(longint'(m_prev) + q);
  endfunction

  function automatic resamp_out_t frame_report();
    resamp_out_t r;
    r = '0;
    r.kind = KIND_REPORT;
    r.last = 1'b1;
    r.fend = 1'b1;
    r.save_smp = m_prev;
    r.save_ph = m_phase;
    return r;
  endfunction

  // Advance the shadow state by one accepted transaction and queue what it owes.
  function automatic void predict_resample(lirs_op_t o, logic signed [15:0] s_in,
                                           logic clr, logic signed [15:0] s_sav,
                                           logic [15:0] p_sav);
    resamp_out_t run[64];
    resamp_out_t r;
    int n;
    int unsigned step;
    int unsigned acc;
    int unsigned carry;
    n = 0;
    if (o == OP_START) begin
      // Restore or clear the history; abandon any open frame.
      if (clr) begin
        m_prev = '0;
        m_phase = '0;
      end else begin
        m_prev = s_sav;
        m_phase = p_sav;
      end
      m_skip = 1'b0;
      m_left = m_frame;
      m_active = 1'b1;
      if (m_left == 0) begin
        resampled_q.push_back(frame_report());
        m_active = 1'b0;
      end
      return;
    end
    if (!m_active) return;
    // Clamp the pitch so one sample never yields more than 64 outputs.
    step = (m_pitch < PITCH_MIN) ? 2 * int'(PITCH_MIN) : 2 * int'(m_pitch);
    if (m_skip) begin
      // Absorb the sample left behind by a double carry.
      m_prev = s_in;
      m_skip = 1'b0;
      if (m_left == 0) begin
        resampled_q.push_back(frame_report());
        m_active = 1'b0;
      end
      return;
    end
    while (m_left > 0 && n < 64) begin
      r = '0;
      r.kind = KIND_SAMPLE;
      r.sample = interp_at(s_in);
      run[n] = r;
      n++;
      m_left--;
      acc = int'(m_phase) + step;
      carry = acc >> 16;
      m_phase = acc[15:0];
      if (carry != 0) begin
        m_prev = s_in;
        if (carry >= 2) m_skip = 1'b1;
        break;
      end
    end
    if (n > 0) begin
      run[n-1].last = 1'b1;
      if (m_left == 0 && !m_skip) begin
        run[n-1].fend = 1'b1;
        run[n-1].save_smp = m_prev;
        run[n-1].save_ph = m_phase;
        m_active = 1'b0;
      end
    end
    for (int i = 0; i < n; i++) resampled_q.push_back(run[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction after a random gap; hold it until accepted, then
  // update the shadow state. Valid stays high on return so that a following
  // zero-gap transaction goes out back to back.
  task automatic drive_item(input lirs_op_t o, input logic [15:0] s, input logic clr,
                            input logic [15:0] ss, input logic [15:0] sp);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= o;
    sample_in <= s;
    clear_history <= clr;
    saved_sample <= ss;
    saved_phase <= sp;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_resample(o, s, clr, ss, sp);
    n_items++;
  endtask

  // Start a frame; the sample field is a don't-care and gets noise.
  task automatic send_start(input logic clr, input logic [15:0] ss, input logic [15:0] sp);
    drive_item(OP_START, 16'($urandom), clr, ss, sp);
  endtask

  // Send one audio sample; the start-only fields get noise.
  task automatic send_sample(input logic [15:0] s);
    drive_item(OP_SAMPLE, s, 1'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Drop valid, drain every owed result and let the pipeline go quiet.
  task automatic settle();
    item_valid <= 1'b0;
    while (resampled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input lirs_reg_t r, input logic [15:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == REG_PITCH) m_pitch = d;
    else m_frame = d[11:0];
  endtask

  // Reprogram both registers; only called with the block idle.
  task automatic configure(input logic [15:0] pitch, input logic [15:0] frame_word);
    settle();
    write_reg(REG_PITCH, pitch);
    write_reg(REG_FRAME, frame_word);
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls and the scoreboard check
  // ---------------------------------------------------------------------------
  int rx_wait = 0;
  int rx_draw;
  resamp_out_t got;
  resamp_out_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (result_valid && result_ready) begin
        got = {kind, sample_out, last_of_run, frame_end, save_sample, save_phase};
        n_results++;
        if (got.kind == KIND_REPORT) n_reports++;
        if (got.fend) n_frame_ends++;
        if (resampled_q.size() == 0) begin
          if (mismatches < MAX_REPORTED)
            $display("unexpected result: kind=%0d sample=%0d last=%0d fend=%0d save=%0d/%h",
                     got.kind, $signed(got.sample), got.last, got.fend,
                     $signed(got.save_smp), got.save_ph);
          mismatches++;
        end else begin
          want = resampled_q.pop_front();
          if (got.kind !== want.kind || got.sample !== want.sample ||
              got.last !== want.last || got.fend !== want.fend ||
              got.save_smp !== want.save_smp || got.save_ph !== want.save_ph) begin
            if (mismatches < MAX_REPORTED) begin
              $display("mismatch at result %0d:", n_results);
              $display("  exp kind=%0d sample=%0d last=%0d fend=%0d save=%0d/%h",
                       want.kind, $signed(want.sample), want.last, want.fend,
                       $signed(want.save_smp), want.save_ph);
              $display("  got kind=%0d sample=%0d last=%0d fend=%0d save=%0d/%h",
                       got.kind, $signed(got.sample), got.last, got.fend,
                       $signed(got.save_smp), got.save_ph);
            end
            mismatches++;
          end
        end
        // Draw the stall before the next result.
        rx_draw = rx_burst ? 0 : $urandom_range(0, 6);
        rx_wait <= rx_draw;
        result_ready <= (rx_draw == 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        result_ready <= (rx_wait == 1);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Hang detection: any transaction on either channel or the register port
  // resets the count.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results owed",
                 HANG_LIMIT, resampled_q.size());
        $display("linear_interp_resampler_core_tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers: one-to-one pitch, long frame. A sample
  // before any start must be dropped.
  task automatic test_reset_values();
    send_sample(16'h1234);
    send_start(1'b1, 16'h7FFF, 16'hFFFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0001);
  endtask

  // Zero outputs per frame: the start itself reports the restored state.
  task automatic test_zero_frame();
    configure(16'hFFFF, 16'h0000);
    send_start(1'b0, 16'h8000, 16'hFFFF);
    send_start(1'b1, 16'h7FFF, 16'h8001);
  endtask

  // Fastest pitch: double carries absorb samples, and the frame closes on a
  // double carry so the next sample comes back as a report. Full-scale swings
  // hit both signs of the product.
  task automatic test_double_carry();
    logic [15:0] seq[7];
    seq = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'h0005};
    configure(16'hFFFF, 16'd3);
    send_start(1'b0, 16'h8000, 16'hFFFF);
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // Pitch under the floor is clamped: 64 outputs per sample. Restart a frame
  // in the middle, then let it end on a plain step and feed one stray sample.
  task automatic test_pitch_clamp();
    configure(16'd511, 16'd66);
    send_start(1'b0, 16'h7FFF, 16'h0000);
    send_sample(16'h8000);
    send_start(1'b1, 16'h1111, 16'h2222);
    send_sample(16'h7FFF);
    send_sample(16'hFFFB);
    send_sample(16'h4321);
  endtask

  // Largest frame at the slowest legal pitch, with no idling on either side.
  task automatic test_long_frame();
    configure(16'd512, 16'hF000 | 16'd4095);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    send_start(1'b1, 16'h0000, 16'h0000);
    while (m_active) send_sample(16'($urandom));
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Random frames under several settings. Mostly well-formed frames with random
  // content; a few mid-frame restarts and stray samples outside a frame.
  task automatic test_random_frames();
    logic [15:0] pitch;
    logic [11:0] frame;
    logic [15:0] s;
    int made;
    int roll;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: pitch = 16'd0;
        1: pitch = 16'd512;
        2: pitch = 16'hFFFF;
        3: pitch = 16'd32768;
        4: pitch = 16'($urandom_range(1, 511));
        5: pitch = 16'($urandom_range(32768, 65535));
        6: pitch = 16'($urandom_range(512, 32767));
        default: pitch = 16'($urandom_range(512, 65535));
      endcase
      frame = (ph == 2) ? 12'd0 : (ph == 5) ? 12'd1 : 12'($urandom_range(2, 24));
      configure(pitch, {4'($urandom), frame});
      tx_burst = (ph % 3 == 1);
      rx_burst = (ph % 4 == 3);
      made = 0;
      while (made < 14) begin
        roll = $urandom_range(0, 99);
        s = (roll % 10 == 0) ? 16'h8000 : (roll % 10 == 1) ? 16'h7FFF : 16'($urandom);
        if (!m_active) begin
          if (roll < 80) begin
            send_start(1'($urandom), 16'($urandom), 16'($urandom));
            made++;
          end else begin
            send_sample(s);   // outside a frame: dropped, not counted
          end
        end else if (roll < 6) begin
          send_start(1'($urandom), 16'($urandom), 16'($urandom));
          made++;
        end else begin
          send_sample(s);
          made++;
        end
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_zero_frame();
    test_double_carry();
    test_pitch_clamp();
    test_long_frame();
    test_random_frames();

    // Drain, then give the block time to show any extra result.
    settle();
    mismatches += resampled_q.size();

    $display("run covered %0d input transactions over %0d register settings",
             n_items, n_settings);
    $display("checked %0d results: %0d reports, %0d frame ends, %0d mismatches",
             n_results, n_reports, n_frame_ends, mismatches);
    if (mismatches == 0) begin
      $display("linear_interp_resampler_core_tb: clean");
    end else begin
      $display("linear_interp_resampler_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lirs_pkg.sv
hdl/lirs_front.sv
hdl/lirs_queue.sv
hdl/lirs_back.sv
hdl/linear_interp_resampler_core.sv
hdl/lirs_checker.sv
sim/linear_interp_resampler_core_tb.sv
